>>> src/kac_pkg.sv
// Package of the keystroke accumulator calculator: widths, character codes,
// enum types and the request/response structs of the shared arithmetic unit.
// Depends on nothing; kac_arith and the top-level calculator use it.
`timescale 1ns / 1ps

package kac_pkg;

  // Accumulator width and number of memory cells.
  localparam int DATA_WIDTH = 32;
  localparam int MEM_CELLS  = 3;
  localparam int CELL_W     = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

  // Character codes of the command stream.
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_STAR    = 8'd42;
  localparam logic [7:0] CH_SLASH   = 8'd47;
  localparam logic [7:0] CH_MEM     = 8'd109;
  localparam logic [7:0] CH_STORE   = 8'd115;
  localparam logic [7:0] CH_LOAD    = 8'd108;
  localparam logic [7:0] CH_GOTO    = 8'd103;
  localparam logic [7:0] CH_GREATER = 8'd62;
  localparam logic [7:0] CH_LESS    = 8'd60;
  localparam logic [7:0] CH_EQUAL   = 8'd61;
  localparam logic [7:0] CH_QUIT    = 8'd113;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NUMBER,
    PH_MEMOP,
    PH_STORE,
    PH_LOAD,
    PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [2:0] {
    EV_ACC,
    EV_STORED,
    EV_LOADED,
    EV_TAKEN,
    EV_NOT_TAKEN,
    EV_HALT,
    EV_DIVZERO,
    EV_BADINDEX
  } event_e;

  // Sequencer states of the arithmetic unit.
  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_FIX,
    U_DONE
  } unit_state_e;

  // Sequencer states of the command parser.
  typedef enum logic [2:0] {
    T_IDLE,
    T_DECODE,
    T_WAIT,
    T_PUSH,
    T_DISPATCH
  } top_state_e;

  typedef struct packed {
    logic                  start;
    op_e                   op;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic                  done;
    logic                  div_zero;
    logic [DATA_WIDTH-1:0] result;
  } arith_rsp_t;

  // True when the character names a memory cell that exists.
  function automatic logic cell_ok(logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return (c >= CH_ZERO) && (c <= CH_NINE) && (int'(d) < MEM_CELLS);
  endfunction

endpackage

>>> src/kac_if.sv
// Stream interfaces of the keystroke accumulator calculator: the character
// input channel and the result channel. Depends on nothing.
`timescale 1ns / 1ps

interface kac_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface kac_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic signed [31:0] acc_value;
  logic [3:0]         cell_index;
  logic               last_of_run;

  modport source (output valid, output event_kind, output acc_value,
                  output cell_index, output last_of_run, input ready);
  modport sink (input valid, input event_kind, input acc_value,
                input cell_index, input last_of_run, output ready);
endinterface

>>> src/kac_arith.sv
// Shared arithmetic unit: registered load, add and subtract, shift-add multiply
// and restoring signed division, one bit per cycle. Depends on kac_pkg.
`timescale 1ns / 1ps

module kac_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kac_pkg::arith_req_t req_i,
  output kac_pkg::arith_rsp_t rsp_o
);

  localparam int DW = kac_pkg::DATA_WIDTH;

  kac_pkg::unit_state_e state_q, state_d;
  logic [DW-1:0]             res_q, res_d;
  logic [DW-1:0]             opa_q, opa_d;   // multiplicand or divisor
  logic [DW-1:0]             opb_q, opb_d;   // multiplier or quotient
  logic [DW-1:0]             rem_q, rem_d;
  logic [kac_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      neg_q, neg_d;
  logic                      dz_q, dz_d;
  logic [DW-1:0]             rem_sh;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kac_pkg::U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    dz_q  <= dz_d;
  end

  // Partial remainder with the next dividend bit shifted in.
  assign rem_sh = {rem_q[DW-2:0], opb_q[DW-1]};

  // Sequencer and datapath.
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    dz_d    = dz_q;
    case (state_q)
      kac_pkg::U_IDLE: begin
        if (req_i.start) begin
          dz_d    = 1'b0;
          state_d = kac_pkg::U_DONE;
          case (req_i.op)
            kac_pkg::OP_ADD: res_d = req_i.a + req_i.b;
            kac_pkg::OP_SUB: res_d = req_i.a - req_i.b;
            kac_pkg::OP_MUL: begin
              res_d   = '0;
              opa_d   = req_i.a;
              opb_d   = req_i.b;
              cnt_d   = kac_pkg::CNT_W'(DW);
              state_d = kac_pkg::U_MUL;
            end
            kac_pkg::OP_DIV: begin
              if (req_i.b == '0) begin
                dz_d = 1'b1;
              end else begin
                neg_d   = req_i.a[DW-1] ^ req_i.b[DW-1];
                opb_d   = req_i.a[DW-1] ? (DW'(0) - req_i.a) : req_i.a;
                opa_d   = req_i.b[DW-1] ? (DW'(0) - req_i.b) : req_i.b;
                rem_d   = '0;
                cnt_d   = kac_pkg::CNT_W'(DW);
                state_d = kac_pkg::U_DIV;
              end
            end
            default: res_d = req_i.b;
          endcase
        end
      end
      kac_pkg::U_MUL: begin
        if (opb_q[0]) begin
          res_d = res_q + opa_q;
        end
        opa_d = {opa_q[DW-2:0], 1'b0};
        opb_d = {1'b0, opb_q[DW-1:1]};
        cnt_d = cnt_q - kac_pkg::CNT_W'(1);
        if (cnt_q == kac_pkg::CNT_W'(1)) begin
          state_d = kac_pkg::U_DONE;
        end
      end
      kac_pkg::U_DIV: begin
        if (rem_sh >= opa_q) begin
          rem_d = rem_sh - opa_q;
          opb_d = {opb_q[DW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          opb_d = {opb_q[DW-2:0], 1'b0};
        end
        cnt_d = cnt_q - kac_pkg::CNT_W'(1);
        if (cnt_q == kac_pkg::CNT_W'(1)) begin
          state_d = kac_pkg::U_FIX;
        end
      end
      kac_pkg::U_FIX: begin
        res_d   = neg_q ? (DW'(0) - opb_q) : opb_q;
        state_d = kac_pkg::U_DONE;
      end
      kac_pkg::U_DONE: begin
        state_d = kac_pkg::U_IDLE;
      end
      default: begin
        state_d = kac_pkg::U_IDLE;
      end
    endcase
  end

  assign rsp_o.done     = (state_q == kac_pkg::U_DONE);
  assign rsp_o.div_zero = dz_q;
  assign rsp_o.result   = res_q;

endmodule

>>> src/keystroke_accumulator_calculator.sv
// Keystroke accumulator calculator: command parser, accumulator, memory cells
// and result register. Depends on kac_pkg, kac_if and kac_arith.
// Multiply and divide run in the bit-per-cycle shared arithmetic unit; a number
// ended by a terminator that emits gives a second beat for it. The parser takes
// no new character until it is through with the last; result stalls hold it.
// Reset clears the control registers and the cells.
`timescale 1ns / 1ps

module keystroke_accumulator_calculator (
  input  logic         clk_i,
  input  logic         rst_ni,
  kac_char_if.sink     char_i,
  kac_result_if.source result_o
);

  localparam int DW = kac_pkg::DATA_WIDTH;

  kac_pkg::top_state_e state_q, state_d;
  kac_pkg::phase_e     phase_q, phase_d;
  kac_pkg::op_e        op_q, op_d;
  kac_pkg::event_e     pend_kind_q, pend_kind_d;
  logic [DW-1:0]       acc_q, acc_d;
  logic [DW-1:0]       build_q, build_d;
  logic                digits_q, digits_d;
  logic [7:0]          char_q, char_d;
  logic [3:0]          pend_cell_q, pend_cell_d;
  logic                pend_last_q, pend_last_d;
  logic                redisp_q, redisp_d;
  logic [DW-1:0]       mem_q [kac_pkg::MEM_CELLS];
  logic                mem_we;
  logic [kac_pkg::CELL_W-1:0] cell_sel;
  logic [DW-1:0]       cell_data;
  logic                cell_valid;
  logic [7:0]          char_digit;
  logic                is_digit;
  logic                out_valid_q;
  logic [2:0]          out_kind_q;
  logic [31:0]         out_acc_q;
  logic [3:0]          out_cell_q;
  logic                out_last_q;
  logic                out_free;
  logic                push;
  kac_pkg::arith_req_t req;
  kac_pkg::arith_rsp_t rsp;

  kac_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Characters that produce a result when dispatched as a command.
  function automatic logic emits_result(logic [7:0] c);
    return (c == kac_pkg::CH_GOTO) || (c == kac_pkg::CH_GREATER) ||
           (c == kac_pkg::CH_LESS) || (c == kac_pkg::CH_EQUAL) ||
           (c == kac_pkg::CH_QUIT);
  endfunction

  // Decoding of the held character.
  assign char_digit = char_q - kac_pkg::CH_ZERO;
  assign is_digit   = (char_q >= kac_pkg::CH_ZERO) && (char_q <= kac_pkg::CH_NINE);
  assign cell_valid = kac_pkg::cell_ok(char_q);
  assign cell_sel   = kac_pkg::CELL_W'(char_digit);
  assign cell_data  = mem_q[cell_sel];

  assign out_free     = !out_valid_q || result_o.ready;
  assign push         = (state_q == kac_pkg::T_PUSH) && out_free;
  assign char_i.ready = (state_q == kac_pkg::T_IDLE);
  assign mem_we       = (state_q == kac_pkg::T_DECODE) && (phase_q == kac_pkg::PH_STORE) &&
                        cell_valid;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kac_pkg::T_IDLE;
      phase_q     <= kac_pkg::PH_IDLE;
      op_q        <= kac_pkg::OP_NONE;
      acc_q       <= '0;
      build_q     <= '0;
      digits_q    <= 1'b0;
      redisp_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      op_q     <= op_d;
      acc_q    <= acc_d;
      build_q  <= build_d;
      digits_q <= digits_d;
      redisp_q <= redisp_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Memory cells, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kac_pkg::MEM_CELLS; i++) begin
        mem_q[i] <= '0;
      end
    end else if (mem_we) begin
      mem_q[cell_sel] <= acc_q;
    end
  end

  // Payload registers: held character, pending result and result register.
  always_ff @(posedge clk_i) begin
    char_q      <= char_d;
    pend_kind_q <= pend_kind_d;
    pend_cell_q <= pend_cell_d;
    pend_last_q <= pend_last_d;
    if (push) begin
      out_kind_q <= pend_kind_q;
      out_acc_q  <= 32'(acc_q);
      out_cell_q <= pend_cell_q;
      out_last_q <= pend_last_q;
    end
  end

  // Parser sequencer.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    op_d        = op_q;
    acc_d       = acc_q;
    build_d     = build_q;
    digits_d    = digits_q;
    redisp_d    = redisp_q;
    char_d      = char_q;
    pend_kind_d = pend_kind_q;
    pend_cell_d = pend_cell_q;
    pend_last_d = pend_last_q;
    req.start   = 1'b0;
    req.op      = op_q;
    req.a       = acc_q;
    req.b       = build_q;
    case (state_q)
      kac_pkg::T_IDLE: begin
        if (char_i.valid) begin
          char_d  = char_i.char_code;
          state_d = kac_pkg::T_DECODE;
        end
      end
      kac_pkg::T_DECODE: begin
        pend_cell_d = '0;
        pend_last_d = 1'b1;
        redisp_d    = 1'b0;
        state_d     = kac_pkg::T_PUSH;
        case (phase_q)
          kac_pkg::PH_NUMBER: begin
            if (is_digit) begin
              build_d  = {build_q[DW-4:0], 3'b000} + {build_q[DW-2:0], 1'b0} +
                         DW'(char_digit);
              digits_d = 1'b1;
              state_d  = kac_pkg::T_IDLE;
            end else if ((char_q == kac_pkg::CH_MEM) && !digits_q &&
                         (op_q != kac_pkg::OP_NONE)) begin
              phase_d = kac_pkg::PH_MEMOP;
              state_d = kac_pkg::T_IDLE;
            end else begin
              // The number ends here; the ending character is dispatched after.
              req.start = 1'b1;
              redisp_d  = 1'b1;
              phase_d   = kac_pkg::PH_IDLE;
              op_d      = kac_pkg::OP_NONE;
              digits_d  = 1'b0;
              state_d   = kac_pkg::T_WAIT;
            end
          end
          kac_pkg::PH_MEMOP: begin
            if (cell_valid) begin
              req.start = 1'b1;
              req.b     = cell_data;
              state_d   = kac_pkg::T_WAIT;
            end else begin
              pend_kind_d = kac_pkg::EV_BADINDEX;
            end
            op_d    = kac_pkg::OP_NONE;
            phase_d = kac_pkg::PH_IDLE;
          end
          kac_pkg::PH_STORE: begin
            if (cell_valid) begin
              pend_kind_d = kac_pkg::EV_STORED;
              pend_cell_d = 4'(char_digit);
            end else begin
              pend_kind_d = kac_pkg::EV_BADINDEX;
            end
            phase_d = kac_pkg::PH_IDLE;
          end
          kac_pkg::PH_LOAD: begin
            if (cell_valid) begin
              acc_d       = cell_data;
              pend_kind_d = kac_pkg::EV_LOADED;
              pend_cell_d = 4'(char_digit);
            end else begin
              pend_kind_d = kac_pkg::EV_BADINDEX;
            end
            phase_d = kac_pkg::PH_IDLE;
          end
          kac_pkg::PH_SKIP: begin
            if (char_q == kac_pkg::CH_NEWLINE) begin
              phase_d = kac_pkg::PH_IDLE;
            end
            state_d = kac_pkg::T_IDLE;
          end
          default: begin
            phase_d = kac_pkg::PH_IDLE;
            state_d = kac_pkg::T_DISPATCH;
          end
        endcase
      end
      kac_pkg::T_WAIT: begin
        if (rsp.done) begin
          if (rsp.div_zero) begin
            pend_kind_d = kac_pkg::EV_DIVZERO;
          end else begin
            acc_d       = rsp.result;
            pend_kind_d = kac_pkg::EV_ACC;
          end
          pend_last_d = redisp_q ? !emits_result(char_q) : 1'b1;
          state_d     = kac_pkg::T_PUSH;
        end
      end
      kac_pkg::T_PUSH: begin
        if (out_free) begin
          redisp_d = 1'b0;
          state_d  = redisp_q ? kac_pkg::T_DISPATCH : kac_pkg::T_IDLE;
        end
      end
      kac_pkg::T_DISPATCH: begin
        pend_cell_d = '0;
        pend_last_d = 1'b1;
        state_d     = kac_pkg::T_IDLE;
        if (is_digit) begin
          build_d  = DW'(char_digit);
          digits_d = 1'b1;
          op_d     = kac_pkg::OP_NONE;
          phase_d  = kac_pkg::PH_NUMBER;
        end else begin
          case (char_q)
            kac_pkg::CH_PLUS, kac_pkg::CH_MINUS, kac_pkg::CH_STAR, kac_pkg::CH_SLASH: begin
              op_d     = (char_q == kac_pkg::CH_PLUS)  ? kac_pkg::OP_ADD :
                         (char_q == kac_pkg::CH_MINUS) ? kac_pkg::OP_SUB :
                         (char_q == kac_pkg::CH_STAR)  ? kac_pkg::OP_MUL : kac_pkg::OP_DIV;
              build_d  = '0;
              digits_d = 1'b0;
              phase_d  = kac_pkg::PH_NUMBER;
            end
            kac_pkg::CH_STORE: phase_d = kac_pkg::PH_STORE;
            kac_pkg::CH_LOAD:  phase_d = kac_pkg::PH_LOAD;
            kac_pkg::CH_GOTO: begin
              pend_kind_d = kac_pkg::EV_TAKEN;
              phase_d     = kac_pkg::PH_SKIP;
              state_d     = kac_pkg::T_PUSH;
            end
            kac_pkg::CH_GREATER: begin
              pend_kind_d = (!acc_q[DW-1] && (acc_q != '0)) ? kac_pkg::EV_TAKEN :
                                                               kac_pkg::EV_NOT_TAKEN;
              phase_d     = kac_pkg::PH_SKIP;
              state_d     = kac_pkg::T_PUSH;
            end
            kac_pkg::CH_LESS: begin
              pend_kind_d = acc_q[DW-1] ? kac_pkg::EV_TAKEN : kac_pkg::EV_NOT_TAKEN;
              phase_d     = kac_pkg::PH_SKIP;
              state_d     = kac_pkg::T_PUSH;
            end
            kac_pkg::CH_EQUAL: begin
              pend_kind_d = (acc_q == '0) ? kac_pkg::EV_TAKEN : kac_pkg::EV_NOT_TAKEN;
              phase_d     = kac_pkg::PH_SKIP;
              state_d     = kac_pkg::T_PUSH;
            end
            kac_pkg::CH_QUIT: begin
              pend_kind_d = kac_pkg::EV_HALT;
              phase_d     = kac_pkg::PH_IDLE;
              state_d     = kac_pkg::T_PUSH;
            end
            default: begin
              state_d = kac_pkg::T_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = kac_pkg::T_IDLE;
      end
    endcase
  end

  // Result channel.
  assign result_o.valid       = out_valid_q;
  assign result_o.event_kind  = out_kind_q;
  assign result_o.acc_value   = out_acc_q;
  assign result_o.cell_index  = out_cell_q;
  assign result_o.last_of_run = out_last_q;

`ifndef NO_ASSERTIONS
  // The arithmetic unit finishes only while the parser waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == kac_pkg::T_WAIT))
    else $error("arithmetic unit finished outside the wait state");

  // Store and load beats name an existing cell.
  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && ((result_o.event_kind == 3'(kac_pkg::EV_STORED)) ||
                        (result_o.event_kind == 3'(kac_pkg::EV_LOADED))))
    |-> (int'(result_o.cell_index) < kac_pkg::MEM_CELLS))
    else $error("cell index out of range on a store or load beat");

  // Every other beat carries cell index zero.
  a_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.event_kind != 3'(kac_pkg::EV_STORED)) &&
     (result_o.event_kind != 3'(kac_pkg::EV_LOADED)))
    |-> (result_o.cell_index == 4'd0))
    else $error("nonzero cell index on a beat without a cell");

  // A result that is not the last of its character is always followed by a dispatch.
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pend_last_q) |-> redisp_q ##1 (state_q == kac_pkg::T_DISPATCH))
    else $error("non-final result without a following dispatch");
`endif

endmodule
